@@ hdl/bounded_ordered_list_engine_defines.svh @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_defines
// Assertion macros shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
// Assert that a condition implies another on the same edge
`define BOLE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Assert that a condition implies another on the next edge
`define BOLE_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ hdl/bole_pkg.sv @@
// ----------------------------------------------------------------------------
// bole_pkg
// Types and constants for the bounded ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package bole_pkg;
    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0, OP_INS_BACK = 3'd1, OP_INS_AFTER = 3'd2,
        OP_DEL_FRONT = 3'd3, OP_DEL_BACK = 3'd4, OP_DEL_VALUE = 3'd5,
        OP_READ = 3'd6, OP_NONE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_EMPTY = 3'd2,
        ST_FULL = 3'd3, ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_WRITE, S_DONE
    } t_state;
endpackage
`default_nettype wire

@@ hdl/bounded_ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Linked list of words in slot memories with a free mask and front/back.
// ----------------------------------------------------------------------------
// After a command is accepted, full, empty and range rejects pass S_WALK then
// S_DONE; inserts at front or back, delete front, the unused opcode and insert
// after on an empty list pass S_WALK, S_WRITE and S_DONE; reads, searches and
// delete back walk from the front one slot per cycle, then S_WRITE and S_DONE.
// A new command can be taken from the cycle after o_done, not before. No result stall.
// Synchronous active-low reset empties the list; slot memories are not cleared.
`default_nettype none
module bounded_ordered_list_engine #(
    parameter int CAPACITY  = bole_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = bole_pkg::WORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      i_opcode,
    input  wire logic signed [bole_pkg::FIELD_BITS-1:0] i_value,
    input  wire logic signed [bole_pkg::FIELD_BITS-1:0] i_match_a,
    input  wire logic signed [bole_pkg::FIELD_BITS-1:0] i_match_b,
    input  wire logic [3:0]                      i_index,
    output logic                                 o_done,
    output logic [2:0]                           o_status,
    output logic signed [bole_pkg::FIELD_BITS-1:0] o_read_value,
    output logic [$clog2(CAPACITY+1)-1:0]        o_entry_count
);
    import bole_pkg::*;
`include "bounded_ordered_list_engine_defines.svh"

    localparam int SB = $clog2(CAPACITY);
    localparam int CB = $clog2(CAPACITY+1);

    // slot memories
    logic [WORD_BITS-1:0] m_val [CAPACITY];
    logic [SB-1:0]        m_lnk [CAPACITY];

    t_state r_state, n_state;
    t_op    r_op;
    logic [WORD_BITS-1:0] r_v, r_ka, r_kb;
    logic [3:0]    r_idx;
    logic [CAPACITY-1:0] r_free;
    logic [SB-1:0] r_front, r_back;
    logic [CB-1:0] r_cnt;
    logic [SB-1:0] r_cur, r_prev;   // slot being read, previous slot
    logic [CB-1:0] r_pos;           // position of r_cur
    logic          r_rdv;           // memory read data valid this cycle
    logic [WORD_BITS-1:0] r_rval;
    logic [SB-1:0] r_rlnk;
    t_status       r_st;
    logic [WORD_BITS-1:0] r_out;

    // sign-extend then trim field to word width
    function automatic logic [WORD_BITS-1:0] word_of(input logic [FIELD_BITS-1:0] f);
        logic [63:0] x;
        x = {{(64-FIELD_BITS){f[FIELD_BITS-1]}}, f};
        return x[WORD_BITS-1:0];
    endfunction

    // lowest free slot
    logic [SB-1:0] w_new;
    always_comb begin
        w_new = '0;
        for (int i = CAPACITY-1; i >= 0; i--)
            if (r_free[i]) w_new = SB'(i);
    end

    wire logic w_full  = (r_cnt == CB'(CAPACITY));
    wire logic w_empty = (r_cnt == '0);
    wire logic w_hit   = (r_rval == r_ka) || (r_rval == r_kb);
    wire logic w_last  = (r_pos == r_cnt - CB'(1));

    // memory read port: first read at r_cur, then straight at the next link
    // while the walk goes on; held once the walk stops so r_rlnk stays put
    logic          w_rd;
    logic [SB-1:0] w_ra;
    assign w_ra = r_rdv ? r_rlnk : r_cur;
    assign w_rd = (r_state == S_WALK) && (!r_rdv || n_state == S_WALK);
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rval <= m_val[w_ra];
            r_rlnk <= m_lnk[w_ra];
        end
    end

    // write-back decisions, evaluated in S_WRITE
    logic          w_we_v, w_we_l, w_we_l2;
    logic [SB-1:0] w_la, w_ld, w_la2, w_ld2;
    always_comb begin
        w_we_v = 1'b0; w_we_l = 1'b0; w_we_l2 = 1'b0;
        w_la = w_new; w_ld = w_new; w_la2 = r_prev; w_ld2 = w_new;
        if (r_state == S_WRITE && r_st == ST_OK) begin
            unique case (r_op)
                OP_INS_FRONT, OP_INS_BACK, OP_INS_AFTER: begin
                    w_we_v = 1'b1; w_we_l = 1'b1;
                    if (w_empty)              w_ld = w_new;
                    else if (r_op == OP_INS_FRONT) w_ld = r_front;
                    else if (r_op == OP_INS_BACK)  w_ld = r_back;
                    else begin
                        w_ld = r_rlnk; w_we_l2 = 1'b1; w_la2 = r_prev; w_ld2 = w_new;
                    end
                    if (r_op == OP_INS_BACK && !w_empty) begin
                        // back entry links to itself; new back does too
                        w_ld = w_new; w_we_l2 = 1'b1; w_la2 = r_back; w_ld2 = w_new;
                    end
                end
                OP_DEL_BACK, OP_DEL_VALUE: begin
                    // r_prev: predecessor, r_cur: removed slot, r_rlnk: its next
                    if (r_pos != '0) begin
                        w_we_l2 = 1'b1; w_la2 = r_prev;
                        w_ld2 = (r_cur == r_back) ? r_prev : r_rlnk;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_v) m_val[w_la] <= r_v;
        if (w_we_l) m_lnk[w_la] <= w_ld;
        if (w_we_l2) m_lnk[w_la2] <= w_ld2;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_WALK;
            S_WALK:  if (!r_rdv) begin
                         if (r_st != ST_OK) n_state = S_DONE;
                         else if (r_op == OP_INS_FRONT || r_op == OP_INS_BACK ||
                                  r_op == OP_DEL_FRONT || r_op == OP_NONE ||
                                  (r_op == OP_INS_AFTER && w_empty))
                             n_state = S_WRITE;
                     end else if (r_op == OP_DEL_BACK) begin
                         if (w_last) n_state = S_WRITE;
                     end else if (r_op == OP_READ) begin
                         if (r_pos == CB'(r_idx)) n_state = S_WRITE;
                     end else if (w_hit) n_state = S_WRITE;
                     else if (w_last) n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '1;
            r_front <= '0;
            r_back  <= '0;
            r_cnt   <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= w_rd;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_op  <= t_op'(i_opcode);
                    r_v   <= word_of(i_value);
                    r_ka  <= word_of(i_match_a);
                    r_kb  <= (i_opcode == OP_DEL_VALUE) ? word_of(i_match_a)
                                                         : word_of(i_match_b);
                    r_idx <= i_index;
                    r_cur <= r_front; r_prev <= r_front;
                    r_pos <= '0; r_out <= '0;
                    if (i_opcode <= OP_INS_AFTER && w_full) r_st <= ST_FULL;
                    else if ((i_opcode >= OP_DEL_FRONT && i_opcode <= OP_READ) && w_empty)
                        r_st <= ST_EMPTY;
                    else if (i_opcode == OP_READ && int'(i_index) >= int'(r_cnt))
                        r_st <= ST_RANGE;
                    else
                        r_st <= ST_OK;
                end
                S_WALK: if (r_rdv && n_state == S_WALK) begin
                    r_prev <= r_cur; r_cur <= r_rlnk; r_pos <= r_pos + CB'(1);
                end else if (r_rdv) begin
                    if (r_op == OP_READ) r_out <= r_rval;
                    else if ((r_op == OP_INS_AFTER || r_op == OP_DEL_VALUE) && !w_hit)
                        r_st <= ST_NOT_FOUND;
                    if (r_op == OP_INS_AFTER) r_prev <= r_cur;
                end
                S_WRITE: if (r_st == ST_OK) begin
                    unique case (r_op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AFTER: begin
                            r_free[w_new] <= 1'b0;
                            r_cnt <= r_cnt + CB'(1);
                            if (w_empty) begin
                                r_front <= w_new; r_back <= w_new;
                            end else if (r_op == OP_INS_FRONT) r_front <= w_new;
                            else if (r_op == OP_INS_BACK) r_back <= w_new;
                            else if (r_prev == r_back) r_back <= w_new;
                        end
                        OP_DEL_FRONT: begin
                            r_free[r_front] <= 1'b1;
                            r_cnt <= r_cnt - CB'(1);
                            if (r_cnt == CB'(1)) begin
                                r_front <= '0; r_back <= '0;
                            end else r_front <= r_rlnk;
                        end
                        OP_DEL_BACK, OP_DEL_VALUE: begin
                            r_free[r_cur] <= 1'b1;
                            r_cnt <= r_cnt - CB'(1);
                            if (r_pos == '0) begin
                                if (r_cnt == CB'(1)) begin
                                    r_front <= '0; r_back <= '0;
                                end else r_front <= r_rlnk;
                            end else if (r_cur == r_back) r_back <= r_prev;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // delete front needs the front link: read it in S_WALK first cycle
    // (r_cur = r_front, read issued on entry; r_rlnk holds the link in S_WRITE)

    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_status      = r_st;
    assign o_read_value  = FIELD_BITS'(r_out);
    assign o_entry_count = r_cnt;

    `BOLE_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CB'(CAPACITY))
    `BOLE_ASSERT_IMP(a_free_cnt, i_clk, i_rst_n, 1'b1, $countones(r_free) == CAPACITY - int'(r_cnt))
    `BOLE_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !o_done && !busy)
endmodule
`default_nettype wire
